[sv/slr_pkg.sv]
// ----------------------------------------------------------------------------
// Sequenced link receiver: shared definitions
// Field widths, action and frame codes, microcode word layout and the
// control program held in read-only form.
// ----------------------------------------------------------------------------
package slr_pkg;

  // Field widths
  localparam int unsigned SEQ_W      = 8;
  localparam int unsigned TAG_W      = 4;
  localparam int unsigned LEN_W      = 12;
  localparam int unsigned XOR_W      = 8;
  localparam int unsigned FTYPE_W    = 3;
  localparam int unsigned TIMER_W    = 16;
  localparam int unsigned GAPCFG_W   = 3;
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned STEP_W     = 6;
  localparam int unsigned CNT_W      = 3;

  // Fixed frame rules
  localparam int unsigned MIN_FRAME_LEN = 5;
  localparam int unsigned TAG_COUNT     = 16;
  localparam int unsigned GAP_CEILING   = 5;
  localparam int unsigned DRAIN_LIMIT   = 4;

  // Register defaults
  localparam logic [TIMER_W-1:0]  TIMEOUT_RST   = 16'd500;
  localparam logic [TIMER_W-1:0]  KA_FIRST_RST  = 16'd20;
  localparam logic [TIMER_W-1:0]  KA_PERIOD_RST = 16'd200;
  localparam logic [GAPCFG_W-1:0] MAX_GAP_RST   = 3'd5;
  localparam logic [SEQ_W-1:0]    STALE_GAP_RST = 8'd240;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_TIMEOUT   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_KA_FIRST  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_KA_PERIOD = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_MAX_GAP   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_STALE_GAP = 3'd4;

  // Frame types
  localparam logic [FTYPE_W-1:0] FT_DATA      = 3'd0;
  localparam logic [FTYPE_W-1:0] FT_KEEPALIVE = 3'd1;
  localparam logic [FTYPE_W-1:0] FT_RETRY     = 3'd2;
  localparam logic [FTYPE_W-1:0] FT_RESET     = 3'd3;

  // Command codes
  localparam logic CMD_FRAME = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  typedef enum logic [2:0] {
    ACT_PUBLISH      = 3'd0,
    ACT_RETRY        = 3'd1,
    ACT_RETRANSMIT   = 3'd2,
    ACT_KEEPALIVE    = 3'd3,
    ACT_CONNECTED    = 3'd4,
    ACT_DISCONNECTED = 3'd5,
    ACT_LINK_RESET   = 3'd6,
    ACT_DISCARD      = 3'd7
  } act_t;

  // Jump conditions of the sequencer
  typedef enum logic [4:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_TICK,
    COND_BAD,
    COND_DATA,
    COND_KEEPALIVE,
    COND_RETRY,
    COND_RESET,
    COND_LINK_UP,
    COND_LINK_DOWN,
    COND_GAP_ONE,
    COND_GAP_DROP,
    COND_GAP_BIG,
    COND_I_DONE,
    COND_KEY_HELD,
    COND_KEY_MISSING,
    COND_NO_FREE,
    COND_DRAIN_DONE,
    COND_IDLE_LOW,
    COND_KA_LOW
  } cond_t;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_FIRST,
    OP_GAP,
    OP_I_ONE,
    OP_I_INC,
    OP_INSERT,
    OP_PUB_IN,
    OP_PUB_HELD,
    OP_LINK_UP,
    OP_LINK_DOWN,
    OP_LINK_RESET,
    OP_IDLE_CLR,
    OP_IDLE_INC,
    OP_KA_INC,
    OP_KA_FIRE
  } op_t;

  // Sequence number searched for in the hold store
  typedef enum logic [1:0] {
    KEY_NEXT,
    KEY_WANT,
    KEY_SEQ
  } key_t;

  typedef enum logic [1:0] {
    SSEL_ZERO,
    SSEL_SEQ,
    SSEL_RETRY,
    SSEL_KEY
  } seqsel_t;

  typedef enum logic [1:0] {
    TSEL_ZERO,
    TSEL_TAG,
    TSEL_HELD
  } tagsel_t;

  typedef logic [STEP_W-1:0] step_t;

  // Program addresses
  localparam step_t ST_IDLE      = 6'd0;
  localparam step_t ST_DISPATCH  = 6'd1;
  localparam step_t ST_CHK_BAD   = 6'd2;
  localparam step_t ST_CHK_DATA  = 6'd3;
  localparam step_t ST_CHK_KA    = 6'd4;
  localparam step_t ST_CHK_RTY   = 6'd5;
  localparam step_t ST_CHK_RST   = 6'd6;
  localparam step_t ST_UNKNOWN   = 6'd7;
  localparam step_t ST_DISCARD   = 6'd8;
  localparam step_t ST_END       = 6'd9;
  localparam step_t ST_KA        = 6'd10;
  localparam step_t ST_KA_CONN   = 6'd11;
  localparam step_t ST_KA_DONE   = 6'd12;
  localparam step_t ST_RETRY     = 6'd13;
  localparam step_t ST_RF        = 6'd14;
  localparam step_t ST_RF_DOWN   = 6'd15;
  localparam step_t ST_RF_RESET  = 6'd16;
  localparam step_t ST_DATA      = 6'd17;
  localparam step_t ST_GAP       = 6'd18;
  localparam step_t ST_GAP_ONE   = 6'd19;
  localparam step_t ST_GAP_DROP  = 6'd20;
  localparam step_t ST_GAP_BIG   = 6'd21;
  localparam step_t ST_HOLD      = 6'd22;
  localparam step_t ST_HLOOP     = 6'd23;
  localparam step_t ST_HCHK      = 6'd24;
  localparam step_t ST_HREQ      = 6'd25;
  localparam step_t ST_HNEXT     = 6'd26;
  localparam step_t ST_HDUP      = 6'd27;
  localparam step_t ST_HINS      = 6'd28;
  localparam step_t ST_HOUT      = 6'd29;
  localparam step_t ST_PUB       = 6'd30;
  localparam step_t ST_DRAIN     = 6'd31;
  localparam step_t ST_DCHK      = 6'd32;
  localparam step_t ST_DPUB      = 6'd33;
  localparam step_t ST_DL        = 6'd34;
  localparam step_t ST_DL_DOWN   = 6'd35;
  localparam step_t ST_DL_RESET  = 6'd36;
  localparam step_t ST_TICK      = 6'd37;
  localparam step_t ST_TCHK      = 6'd38;
  localparam step_t ST_TO        = 6'd39;
  localparam step_t ST_TO_DOWN   = 6'd40;
  localparam step_t ST_TO_RESET  = 6'd41;
  localparam step_t ST_KTICK     = 6'd42;
  localparam step_t ST_KCHK      = 6'd43;
  localparam step_t ST_KFIRE     = 6'd44;

  // One control word of the program
  typedef struct packed {
    cond_t   cond;
    step_t   target;
    op_t     op;
    key_t    key;
    logic    emit;
    act_t    act;
    seqsel_t ssel;
    tagsel_t tsel;
    logic    fin;
  } ucode_t;

  // Controls handed from the sequencer to the datapath
  typedef struct packed {
    op_t     op;
    key_t    key;
    act_t    act;
    seqsel_t ssel;
    tagsel_t tsel;
  } dp_ctrl_t;

  // Flags that the sequencer tests
  typedef struct packed {
    logic is_tick;
    logic bad;
    logic is_data;
    logic is_ka;
    logic is_retry;
    logic is_reset;
    logic link_up;
    logic gap_one;
    logic gap_drop;
    logic gap_big;
    logic i_done;
    logic key_held;
    logic no_free;
    logic drain_done;
    logic idle_low;
    logic ka_low;
  } dp_status_t;

  typedef struct packed {
    act_t             act;
    logic [SEQ_W-1:0] seq;
    logic [TAG_W-1:0] tag;
  } result_t;

  // Builds one control word.
  function automatic ucode_t uw(input cond_t c, input step_t t, input op_t o,
                                input key_t k, input logic e, input act_t a,
                                input seqsel_t s, input tagsel_t g,
                                input logic f);
    ucode_t w;
    w.cond   = c;
    w.target = t;
    w.op     = o;
    w.key    = k;
    w.emit   = e;
    w.act    = a;
    w.ssel   = s;
    w.tsel   = g;
    w.fin    = f;
    return w;
  endfunction

  // Control program. A word whose condition holds jumps to its target,
  // otherwise the next word follows.
  function automatic ucode_t ucode(input step_t step);
    ucode_t w;
    w = uw(COND_ALWAYS, ST_IDLE, OP_NONE, KEY_NEXT, 1'b0, ACT_PUBLISH,
           SSEL_ZERO, TSEL_ZERO, 1'b0);
    unique case (step)
      // Wait for a word, then sort it
      ST_IDLE:     w.cond = COND_NO_INPUT;
      ST_DISPATCH: begin w.cond = COND_TICK;      w.target = ST_TICK;    end
      ST_CHK_BAD:  begin w.cond = COND_BAD;       w.target = ST_DISCARD; end
      ST_CHK_DATA: begin w.cond = COND_DATA;      w.target = ST_DATA;    end
      ST_CHK_KA:   begin w.cond = COND_KEEPALIVE; w.target = ST_KA;      end
      ST_CHK_RTY:  begin w.cond = COND_RETRY;     w.target = ST_RETRY;   end
      ST_CHK_RST:  begin w.cond = COND_RESET;     w.target = ST_RF;      end
      ST_UNKNOWN:  w.target = ST_DISCARD;
      // Common tail: discard the frame, then close the item
      ST_DISCARD:  w = uw(COND_NEVER, ST_IDLE, OP_NONE, KEY_NEXT, 1'b1, ACT_DISCARD,
                          SSEL_ZERO, TSEL_TAG, 1'b0);
      ST_END:      w.fin = 1'b1;
      // Keepalive frame
      ST_KA:       begin w.cond = COND_LINK_UP; w.target = ST_KA_DONE; end
      ST_KA_CONN:  w = uw(COND_NEVER, ST_IDLE, OP_LINK_UP, KEY_NEXT, 1'b1,
                          ACT_CONNECTED, SSEL_ZERO, TSEL_ZERO, 1'b0);
      ST_KA_DONE:  begin w.op = OP_IDLE_CLR; w.target = ST_DISCARD; end
      // Retry frame
      ST_RETRY:    w = uw(COND_ALWAYS, ST_DISCARD, OP_NONE, KEY_NEXT, 1'b1,
                          ACT_RETRANSMIT, SSEL_RETRY, TSEL_ZERO, 1'b0);
      // Reset frame
      ST_RF:       begin w.cond = COND_LINK_DOWN; w.target = ST_RF_RESET; end
      ST_RF_DOWN:  w = uw(COND_NEVER, ST_IDLE, OP_LINK_DOWN, KEY_NEXT, 1'b1,
                          ACT_DISCONNECTED, SSEL_ZERO, TSEL_ZERO, 1'b0);
      ST_RF_RESET: w = uw(COND_ALWAYS, ST_DISCARD, OP_LINK_RESET, KEY_NEXT, 1'b1,
                          ACT_LINK_RESET, SSEL_ZERO, TSEL_ZERO, 1'b0);
      // Data frame: classify by gap
      ST_DATA:     begin w.cond = COND_NEVER; w.op = OP_FIRST; end
      ST_GAP:      begin w.cond = COND_NEVER; w.op = OP_GAP; end
      ST_GAP_ONE:  begin w.cond = COND_GAP_ONE;  w.target = ST_PUB;     end
      ST_GAP_DROP: begin w.cond = COND_GAP_DROP; w.target = ST_DISCARD; end
      ST_GAP_BIG:  begin w.cond = COND_GAP_BIG;  w.target = ST_DL;      end
      // Small gap: request the missing numbers, then hold the frame
      ST_HOLD:     begin w.cond = COND_NEVER; w.op = OP_I_ONE; end
      ST_HLOOP:    begin w.cond = COND_I_DONE; w.target = ST_HDUP; end
      ST_HCHK:     begin
        w.cond = COND_KEY_HELD; w.target = ST_HNEXT; w.key = KEY_WANT;
      end
      ST_HREQ:     w = uw(COND_NEVER, ST_IDLE, OP_NONE, KEY_WANT, 1'b1, ACT_RETRY,
                          SSEL_KEY, TSEL_ZERO, 1'b0);
      ST_HNEXT:    begin w.op = OP_I_INC; w.target = ST_HLOOP; end
      ST_HDUP:     begin
        w.cond = COND_KEY_HELD; w.target = ST_DISCARD; w.key = KEY_SEQ;
      end
      ST_HINS:     begin w.cond = COND_NO_FREE; w.target = ST_DISCARD; w.op = OP_INSERT; end
      ST_HOUT:     w.target = ST_END;
      // Next in order: publish, then drain held frames
      ST_PUB:      w = uw(COND_NEVER, ST_IDLE, OP_PUB_IN, KEY_NEXT, 1'b1, ACT_PUBLISH,
                          SSEL_SEQ, TSEL_TAG, 1'b0);
      ST_DRAIN:    begin w.cond = COND_DRAIN_DONE;  w.target = ST_END; end
      ST_DCHK:     begin w.cond = COND_KEY_MISSING; w.target = ST_END; end
      ST_DPUB:     w = uw(COND_ALWAYS, ST_DRAIN, OP_PUB_HELD, KEY_NEXT, 1'b1,
                          ACT_PUBLISH, SSEL_KEY, TSEL_HELD, 1'b0);
      // Gap too large: link reset, then discard
      ST_DL:       begin w.cond = COND_LINK_DOWN; w.target = ST_DL_RESET; end
      ST_DL_DOWN:  w = uw(COND_NEVER, ST_IDLE, OP_LINK_DOWN, KEY_NEXT, 1'b1,
                          ACT_DISCONNECTED, SSEL_ZERO, TSEL_ZERO, 1'b0);
      ST_DL_RESET: w = uw(COND_ALWAYS, ST_DISCARD, OP_LINK_RESET, KEY_NEXT, 1'b1,
                          ACT_LINK_RESET, SSEL_ZERO, TSEL_ZERO, 1'b0);
      // Tick: idle timeout first, then keepalive timer
      ST_TICK:     begin w.cond = COND_NEVER; w.op = OP_IDLE_INC; end
      ST_TCHK:     begin w.cond = COND_IDLE_LOW; w.target = ST_KTICK; end
      ST_TO:       begin
        w.cond = COND_LINK_DOWN; w.target = ST_TO_RESET; w.op = OP_IDLE_CLR;
      end
      ST_TO_DOWN:  w = uw(COND_NEVER, ST_IDLE, OP_LINK_DOWN, KEY_NEXT, 1'b1,
                          ACT_DISCONNECTED, SSEL_ZERO, TSEL_ZERO, 1'b0);
      ST_TO_RESET: w = uw(COND_NEVER, ST_IDLE, OP_LINK_RESET, KEY_NEXT, 1'b1,
                          ACT_LINK_RESET, SSEL_ZERO, TSEL_ZERO, 1'b0);
      ST_KTICK:    begin w.cond = COND_NEVER; w.op = OP_KA_INC; end
      ST_KCHK:     begin w.cond = COND_KA_LOW; w.target = ST_END; end
      ST_KFIRE:    w = uw(COND_ALWAYS, ST_END, OP_KA_FIRE, KEY_NEXT, 1'b1,
                          ACT_KEEPALIVE, SSEL_ZERO, TSEL_ZERO, 1'b0);
      default:     w.target = ST_IDLE;
    endcase
    return w;
  endfunction

endpackage

[sv/sequenced_link_receiver_unit.sv]
// ----------------------------------------------------------------------------
// Sequenced link receiver
// Receive-side sequencer of a framed link with 8-bit sequence numbers,
// driven by a microcoded control program over a small datapath.
// ----------------------------------------------------------------------------
// Flow: one word at a time; a new word is taken only while the program waits
//   at its first step, and a step that hands on a result can stall on the output.
// Results: a result waits in the pending register until the next result or the
//   end of its word, then passes on to the output register.
// Reset: synchronous, active low; registers take their defaults, the hold
//   store is emptied and the link is down, awaiting its first frame.
module sequenced_link_receiver_unit #(
  parameter int unsigned HOLD_DEPTH = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Configuration
  input  logic                              cfg_we,
  input  logic [slr_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [slr_pkg::CFG_W-1:0]         cfg_wdata,
  // Input words
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_command,
  input  logic [slr_pkg::FTYPE_W-1:0]       in_frame_type,
  input  logic [slr_pkg::SEQ_W-1:0]         in_seq,
  input  logic [slr_pkg::SEQ_W-1:0]         in_retry_seq,
  input  logic [slr_pkg::LEN_W-1:0]         in_frame_len,
  input  logic [slr_pkg::XOR_W-1:0]         in_xor_sum,
  input  logic [slr_pkg::TAG_W-1:0]         in_tag,
  // Result words
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [2:0]                        out_action,
  output logic [slr_pkg::SEQ_W-1:0]         out_seq,
  output logic [slr_pkg::TAG_W-1:0]         out_tag,
  output logic                              out_last
);

  logic                at_idle;
  logic                in_accept;
  logic                res_busy;
  logic                emit_fire;
  logic                flush_fire;
  slr_pkg::dp_ctrl_t   ctrl;
  slr_pkg::dp_status_t status;
  slr_pkg::result_t    res;

  // A new word is taken only while the program waits at its first step
  assign in_stall  = !(at_idle && rst_n);
  assign in_accept = in_valid && !in_stall;

  slr_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_accept  (in_accept),
    .status     (status),
    .res_busy   (res_busy),
    .at_idle    (at_idle),
    .ctrl       (ctrl),
    .emit_fire  (emit_fire),
    .flush_fire (flush_fire)
  );

  slr_datapath #(
    .HOLD_DEPTH (HOLD_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .in_accept     (in_accept),
    .in_command    (in_command),
    .in_frame_type (in_frame_type),
    .in_seq        (in_seq),
    .in_retry_seq  (in_retry_seq),
    .in_frame_len  (in_frame_len),
    .in_xor_sum    (in_xor_sum),
    .in_tag        (in_tag),
    .ctrl          (ctrl),
    .status        (status),
    .res           (res)
  );

  slr_result u_result (
    .clk        (clk),
    .rst_n      (rst_n),
    .emit_fire  (emit_fire),
    .flush_fire (flush_fire),
    .res        (res),
    .out_stall  (out_stall),
    .res_busy   (res_busy),
    .out_valid  (out_valid),
    .out_action (out_action),
    .out_seq    (out_seq),
    .out_tag    (out_tag),
    .out_last   (out_last)
  );

endmodule

[sv/slr_seq.sv]
// ----------------------------------------------------------------------------
// Sequenced link receiver: microcode sequencer
// Step counter over the control program, condition select and jump, and
// the stall of a step whose result cannot yet be handed on.
// ----------------------------------------------------------------------------
module slr_seq (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_accept,
  input  slr_pkg::dp_status_t   status,
  input  logic                  res_busy,
  output logic                  at_idle,
  output slr_pkg::dp_ctrl_t     ctrl,
  output logic                  emit_fire,
  output logic                  flush_fire
);

  slr_pkg::step_t  step_r;
  slr_pkg::step_t  step_nxt;
  slr_pkg::ucode_t word;
  logic            go;
  logic            take;

  // Current control word
  assign word = slr_pkg::ucode(step_r);

  // A step that hands on a result waits while the result stage is full
  assign go = !((word.emit || word.fin) && res_busy);

  // Condition select
  always_comb begin
    unique case (word.cond)
      slr_pkg::COND_NEVER:       take = 1'b0;
      slr_pkg::COND_ALWAYS:      take = 1'b1;
      slr_pkg::COND_NO_INPUT:    take = !in_accept;
      slr_pkg::COND_TICK:        take = status.is_tick;
      slr_pkg::COND_BAD:         take = status.bad;
      slr_pkg::COND_DATA:        take = status.is_data;
      slr_pkg::COND_KEEPALIVE:   take = status.is_ka;
      slr_pkg::COND_RETRY:       take = status.is_retry;
      slr_pkg::COND_RESET:       take = status.is_reset;
      slr_pkg::COND_LINK_UP:     take = status.link_up;
      slr_pkg::COND_LINK_DOWN:   take = !status.link_up;
      slr_pkg::COND_GAP_ONE:     take = status.gap_one;
      slr_pkg::COND_GAP_DROP:    take = status.gap_drop;
      slr_pkg::COND_GAP_BIG:     take = status.gap_big;
      slr_pkg::COND_I_DONE:      take = status.i_done;
      slr_pkg::COND_KEY_HELD:    take = status.key_held;
      slr_pkg::COND_KEY_MISSING: take = !status.key_held;
      slr_pkg::COND_NO_FREE:     take = status.no_free;
      slr_pkg::COND_DRAIN_DONE:  take = status.drain_done;
      slr_pkg::COND_IDLE_LOW:    take = status.idle_low;
      slr_pkg::COND_KA_LOW:      take = status.ka_low;
      default:                   take = 1'b0;
    endcase
  end

  // Next step
  always_comb begin
    if (!go) begin
      step_nxt = step_r;
    end else if (take) begin
      step_nxt = word.target;
    end else begin
      step_nxt = step_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= slr_pkg::ST_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  // Controls to the datapath; a stalled step does nothing
  always_comb begin
    ctrl.op   = go ? word.op : slr_pkg::OP_NONE;
    ctrl.key  = word.key;
    ctrl.act  = word.act;
    ctrl.ssel = word.ssel;
    ctrl.tsel = word.tsel;
  end

  assign emit_fire  = word.emit && go;
  assign flush_fire = word.fin && go;
  assign at_idle    = (step_r == slr_pkg::ST_IDLE);

endmodule

[sv/slr_datapath.sv]
// ----------------------------------------------------------------------------
// Sequenced link receiver: datapath
// Configuration registers, the latched word, link state, timers and the
// store of held frames, worked by the operations of the control program.
// ----------------------------------------------------------------------------
module slr_datapath #(
  parameter int unsigned HOLD_DEPTH = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [slr_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [slr_pkg::CFG_W-1:0]         cfg_wdata,
  input  logic                              in_accept,
  input  logic                              in_command,
  input  logic [slr_pkg::FTYPE_W-1:0]       in_frame_type,
  input  logic [slr_pkg::SEQ_W-1:0]         in_seq,
  input  logic [slr_pkg::SEQ_W-1:0]         in_retry_seq,
  input  logic [slr_pkg::LEN_W-1:0]         in_frame_len,
  input  logic [slr_pkg::XOR_W-1:0]         in_xor_sum,
  input  logic [slr_pkg::TAG_W-1:0]         in_tag,
  input  slr_pkg::dp_ctrl_t                 ctrl,
  output slr_pkg::dp_status_t               status,
  output slr_pkg::result_t                  res
);

  localparam int unsigned HIDX_W    = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
  localparam int unsigned DRAIN_LIM = (HOLD_DEPTH < slr_pkg::DRAIN_LIMIT) ?
                                      HOLD_DEPTH : slr_pkg::DRAIN_LIMIT;

  // Configuration
  logic [slr_pkg::TIMER_W-1:0]  timeout_r;
  logic [slr_pkg::TIMER_W-1:0]  ka_first_r;
  logic [slr_pkg::TIMER_W-1:0]  ka_period_r;
  logic [slr_pkg::GAPCFG_W-1:0] max_gap_r;
  logic [slr_pkg::SEQ_W-1:0]    stale_gap_r;

  // Latched word
  logic                         cmd_r;
  logic [slr_pkg::FTYPE_W-1:0]  ftype_r;
  logic [slr_pkg::SEQ_W-1:0]    seq_r;
  logic [slr_pkg::SEQ_W-1:0]    rseq_r;
  logic [slr_pkg::LEN_W-1:0]    len_r;
  logic [slr_pkg::XOR_W-1:0]    xs_r;
  logic [slr_pkg::TAG_W-1:0]    tag_r;

  // Link state and scratch
  logic [slr_pkg::SEQ_W-1:0]    delivered_r;
  logic                         awaiting_r;
  logic                         link_up_r;
  logic [slr_pkg::TIMER_W-1:0]  idle_r;
  logic [slr_pkg::TIMER_W-1:0]  ka_r;
  logic                         fkd_r;
  logic [slr_pkg::SEQ_W-1:0]    gap_r;
  logic [slr_pkg::CNT_W-1:0]    cnt_r;

  // Hold store
  logic [HOLD_DEPTH-1:0]        held_valid_r;
  logic [slr_pkg::SEQ_W-1:0]    held_seq_r [HOLD_DEPTH];
  logic [slr_pkg::TAG_W-1:0]    held_tag_r [HOLD_DEPTH];

  logic [slr_pkg::SEQ_W-1:0]    key;
  logic [HOLD_DEPTH-1:0]        hit;
  logic [HIDX_W-1:0]            hit_idx;
  logic [HIDX_W-1:0]            free_idx;
  logic                         key_held;
  logic                         no_free;
  logic [slr_pkg::GAPCFG_W-1:0] eff_gap;
  logic [slr_pkg::TIMER_W-1:0]  idle_lim;
  logic [slr_pkg::TIMER_W-1:0]  ka_lim;

  // Search key for the hold store
  always_comb begin
    unique case (ctrl.key)
      slr_pkg::KEY_NEXT: key = delivered_r + 1'b1;
      slr_pkg::KEY_WANT: key = delivered_r + {{(slr_pkg::SEQ_W-slr_pkg::CNT_W){1'b0}}, cnt_r};
      slr_pkg::KEY_SEQ:  key = seq_r;
      default:           key = seq_r;
    endcase
  end

  // Parallel compare against every held entry, lowest match and lowest free
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < HOLD_DEPTH; i++) begin
      hit[i] = held_valid_r[i] && (held_seq_r[i] == key);
    end
    for (int i = HOLD_DEPTH - 1; i >= 0; i--) begin
      if (hit[i]) begin
        hit_idx = HIDX_W'(i);
      end
      if (!held_valid_r[i]) begin
        free_idx = HIDX_W'(i);
      end
    end
  end

  assign key_held = |hit;
  assign no_free  = &held_valid_r;

  // Limits with their floors and ceilings applied
  assign eff_gap  = (max_gap_r > slr_pkg::GAPCFG_W'(slr_pkg::GAP_CEILING)) ?
                    slr_pkg::GAPCFG_W'(slr_pkg::GAP_CEILING) : max_gap_r;
  assign idle_lim = (timeout_r == '0) ? slr_pkg::TIMER_W'(1) : timeout_r;
  assign ka_lim   = fkd_r ? ((ka_period_r == '0) ? slr_pkg::TIMER_W'(1) : ka_period_r)
                          : ((ka_first_r == '0) ? slr_pkg::TIMER_W'(1) : ka_first_r);

  // Flags for the sequencer
  always_comb begin
    status.is_tick    = (cmd_r == slr_pkg::CMD_TICK);
    status.bad        = (len_r < slr_pkg::LEN_W'(slr_pkg::MIN_FRAME_LEN)) || (xs_r != '0) ||
                        ({1'b0, tag_r} >= 5'(slr_pkg::TAG_COUNT - 1) + 5'd1);
    status.is_data    = (ftype_r == slr_pkg::FT_DATA);
    status.is_ka      = (ftype_r == slr_pkg::FT_KEEPALIVE);
    status.is_retry   = (ftype_r == slr_pkg::FT_RETRY);
    status.is_reset   = (ftype_r == slr_pkg::FT_RESET);
    status.link_up    = link_up_r;
    status.gap_one    = (gap_r == slr_pkg::SEQ_W'(1));
    status.gap_drop   = (gap_r == '0) || (gap_r > stale_gap_r);
    status.gap_big    = (gap_r > {{(slr_pkg::SEQ_W-slr_pkg::GAPCFG_W){1'b0}}, eff_gap});
    status.i_done     = ({{(slr_pkg::SEQ_W-slr_pkg::CNT_W){1'b0}}, cnt_r} >= gap_r);
    status.key_held   = key_held;
    status.no_free    = no_free;
    status.drain_done = (cnt_r >= slr_pkg::CNT_W'(DRAIN_LIM));
    status.idle_low   = (idle_r < idle_lim);
    status.ka_low     = (ka_r < ka_lim);
  end

  // Result fields
  always_comb begin
    res.act = ctrl.act;
    unique case (ctrl.ssel)
      slr_pkg::SSEL_ZERO:  res.seq = '0;
      slr_pkg::SSEL_SEQ:   res.seq = seq_r;
      slr_pkg::SSEL_RETRY: res.seq = rseq_r;
      slr_pkg::SSEL_KEY:   res.seq = key;
      default:             res.seq = '0;
    endcase
    unique case (ctrl.tsel)
      slr_pkg::TSEL_ZERO: res.tag = '0;
      slr_pkg::TSEL_TAG:  res.tag = tag_r;
      slr_pkg::TSEL_HELD: res.tag = held_tag_r[hit_idx];
      default:            res.tag = '0;
    endcase
  end

  // Word latch and held payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_r   <= in_command;
      ftype_r <= in_frame_type;
      seq_r   <= in_seq;
      rseq_r  <= in_retry_seq;
      len_r   <= in_frame_len;
      xs_r    <= in_xor_sum;
      tag_r   <= in_tag;
    end
    if (ctrl.op == slr_pkg::OP_INSERT && !no_free) begin
      held_seq_r[free_idx] <= seq_r;
      held_tag_r[free_idx] <= tag_r;
    end
    if (ctrl.op == slr_pkg::OP_GAP) begin
      gap_r <= seq_r - delivered_r;
    end
    if (ctrl.op == slr_pkg::OP_I_ONE) begin
      cnt_r <= slr_pkg::CNT_W'(1);
    end else if (ctrl.op == slr_pkg::OP_PUB_IN) begin
      cnt_r <= '0;
    end else if (ctrl.op == slr_pkg::OP_I_INC || ctrl.op == slr_pkg::OP_PUB_HELD) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r   <= slr_pkg::TIMEOUT_RST;
      ka_first_r  <= slr_pkg::KA_FIRST_RST;
      ka_period_r <= slr_pkg::KA_PERIOD_RST;
      max_gap_r   <= slr_pkg::MAX_GAP_RST;
      stale_gap_r <= slr_pkg::STALE_GAP_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        slr_pkg::CFG_TIMEOUT:   timeout_r   <= cfg_wdata;
        slr_pkg::CFG_KA_FIRST:  ka_first_r  <= cfg_wdata;
        slr_pkg::CFG_KA_PERIOD: ka_period_r <= cfg_wdata;
        slr_pkg::CFG_MAX_GAP:   max_gap_r   <= cfg_wdata[slr_pkg::GAPCFG_W-1:0];
        slr_pkg::CFG_STALE_GAP: stale_gap_r <= cfg_wdata[slr_pkg::SEQ_W-1:0];
        default: ;
      endcase
    end
  end

  // Link state, timers and held valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delivered_r  <= '0;
      awaiting_r   <= 1'b1;
      link_up_r    <= 1'b0;
      idle_r       <= '0;
      ka_r         <= '0;
      fkd_r        <= 1'b0;
      held_valid_r <= '0;
    end else begin
      unique case (ctrl.op)
        slr_pkg::OP_FIRST: begin
          if (awaiting_r) begin
            delivered_r <= seq_r - 1'b1;
            awaiting_r  <= 1'b0;
          end
          idle_r <= '0;
        end
        slr_pkg::OP_INSERT: begin
          if (!no_free) begin
            held_valid_r[free_idx] <= 1'b1;
          end
        end
        slr_pkg::OP_PUB_IN:    delivered_r <= seq_r;
        slr_pkg::OP_PUB_HELD: begin
          delivered_r           <= key;
          held_valid_r[hit_idx] <= 1'b0;
        end
        slr_pkg::OP_LINK_UP:   link_up_r <= 1'b1;
        slr_pkg::OP_LINK_DOWN: link_up_r <= 1'b0;
        slr_pkg::OP_LINK_RESET: begin
          delivered_r  <= '0;
          awaiting_r   <= 1'b1;
          held_valid_r <= '0;
        end
        slr_pkg::OP_IDLE_CLR:  idle_r <= '0;
        slr_pkg::OP_IDLE_INC: begin
          if (idle_r != '1) begin
            idle_r <= idle_r + 1'b1;
          end
        end
        slr_pkg::OP_KA_INC: begin
          if (ka_r != '1) begin
            ka_r <= ka_r + 1'b1;
          end
        end
        slr_pkg::OP_KA_FIRE: begin
          ka_r  <= '0;
          fkd_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // A link reset empties the hold store and rearms the first-frame rule.
  a_reset_clears: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.op == slr_pkg::OP_LINK_RESET |=> held_valid_r == '0 && awaiting_r)
    else $error("link reset left held entries or first-frame flag");

  // Inserting into a store with a free slot adds exactly one entry.
  a_insert_one: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == slr_pkg::OP_INSERT && !no_free) |=>
      $countones(held_valid_r) == $past($countones(held_valid_r)) + 1)
    else $error("insert did not add exactly one held entry");

  // A drain step only publishes an entry that is really held.
  a_drain_hit: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.op == slr_pkg::OP_PUB_HELD |-> key_held)
    else $error("drain publish without a matching held entry");
`endif

endmodule

[sv/slr_result.sv]
// ----------------------------------------------------------------------------
// Sequenced link receiver: result stage
// Keeps the newest result pending until the next one or the end of the word
// shows whether it is the last, then passes it to the output register.
// ----------------------------------------------------------------------------
module slr_result (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       emit_fire,
  input  logic                       flush_fire,
  input  slr_pkg::result_t           res,
  input  logic                       out_stall,
  output logic                       res_busy,
  output logic                       out_valid,
  output logic [2:0]                 out_action,
  output logic [slr_pkg::SEQ_W-1:0]  out_seq,
  output logic [slr_pkg::TAG_W-1:0]  out_tag,
  output logic                       out_last
);

  logic             pend_v_r;
  slr_pkg::result_t pend_r;
  logic             out_v_r;
  slr_pkg::result_t out_r;
  logic             out_last_r;
  logic             push;

  // The pending result moves on when a newer one arrives or the word ends
  assign push     = pend_v_r && (emit_fire || flush_fire);
  assign res_busy = pend_v_r && out_v_r && out_stall;

  // Control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (emit_fire) begin
        pend_v_r <= 1'b1;
      end else if (flush_fire) begin
        pend_v_r <= 1'b0;
      end
      if (push) begin
        out_v_r <= 1'b1;
      end else if (out_v_r && !out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (emit_fire) begin
      pend_r <= res;
    end
    if (push) begin
      out_r      <= pend_r;
      out_last_r <= flush_fire;
    end
  end

  assign out_valid  = out_v_r;
  assign out_action = out_r.act;
  assign out_seq    = out_r.seq;
  assign out_tag    = out_r.tag;
  assign out_last   = out_last_r;

`ifndef NO_ASSERTIONS
  // A result never overwrites a word still waiting at the output.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!out_v_r || !out_stall))
    else $error("output word overwritten while stalled");

  // Closing a word leaves nothing pending.
  a_flush_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (flush_fire && !emit_fire) |=> !pend_v_r)
    else $error("pending result left after end of word");

  // A new result is captured unchanged.
  a_emit_capture: assert property (@(posedge clk) disable iff (!rst_n)
    emit_fire |=> (pend_v_r && pend_r == $past(res)))
    else $error("emitted result not captured");
`endif

endmodule

[tb/sequenced_link_receiver_unit_tb.sv]
// ----------------------------------------------------------------------------
// Sequenced link receiver: self-checking testbench
// Feeds frame descriptors and timer ticks through the input channel, keeps
// its own model of the receive sequencer and compares every result word,
// field by field, against the actions that model foresees. Both channels
// idle and stall in random bursts, and the registers are swept between phases.
// ----------------------------------------------------------------------------
module sequenced_link_receiver_unit_tb;

  localparam int HOLD_SLOTS    = 4;
  localparam int MAX_ACTIONS   = 5;
  localparam int PHASE_WORDS   = 60;
  localparam int SETTLE_CYCLES = 64;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int FAULT_SHOWN   = 10;
  localparam logic [slr_pkg::FTYPE_W-1:0] FT_OTHER_FIRST = 3'd4;
  localparam logic [slr_pkg::FTYPE_W-1:0] FT_OTHER_LAST  = 3'd7;

  // One input word as the sender sees it.
  typedef struct packed {
    logic                        command;
    logic [slr_pkg::FTYPE_W-1:0] ftype;
    logic [slr_pkg::SEQ_W-1:0]   seq;
    logic [slr_pkg::SEQ_W-1:0]   rseq;
    logic [slr_pkg::LEN_W-1:0]   len;
    logic [slr_pkg::XOR_W-1:0]   xsum;
    logic [slr_pkg::TAG_W-1:0]   tag;
  } word_t;

  // One result word.
  typedef struct packed {
    slr_pkg::act_t             act;
    logic [slr_pkg::SEQ_W-1:0] seq;
    logic [slr_pkg::TAG_W-1:0] tag;
    logic                      last;
  } report_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                           cfg_we    = 1'b0;
  logic [slr_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [slr_pkg::CFG_W-1:0]      cfg_wdata = '0;

  logic                        in_valid      = 1'b0;
  logic                        in_stall;
  logic                        in_command    = 1'b0;
  logic [slr_pkg::FTYPE_W-1:0] in_frame_type = '0;
  logic [slr_pkg::SEQ_W-1:0]   in_seq        = '0;
  logic [slr_pkg::SEQ_W-1:0]   in_retry_seq  = '0;
  logic [slr_pkg::LEN_W-1:0]   in_frame_len  = '0;
  logic [slr_pkg::XOR_W-1:0]   in_xor_sum    = '0;
  logic [slr_pkg::TAG_W-1:0]   in_tag        = '0;

  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [2:0]                out_action;
  logic [slr_pkg::SEQ_W-1:0] out_seq;
  logic [slr_pkg::TAG_W-1:0] out_tag;
  logic                      out_last;

  sequenced_link_receiver_unit DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_command    (in_command),
    .in_frame_type (in_frame_type),
    .in_seq        (in_seq),
    .in_retry_seq  (in_retry_seq),
    .in_frame_len  (in_frame_len),
    .in_xor_sum    (in_xor_sum),
    .in_tag        (in_tag),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_action    (out_action),
    .out_seq       (out_seq),
    .out_tag       (out_tag),
    .out_last      (out_last)
  );

  always #2 clk = ~clk;

  // Stimulus and scoreboard bookkeeping.
  word_t       outgoing_words[$];
  report_t     due_actions[$];
  report_t     word_actions[$];
  int          words_queued = 0;
  int          words_taken  = 0;
  int          fault_count  = 0;
  int          cycle_count  = 0;
  bit          calm         = 1'b0;
  logic [slr_pkg::SEQ_W-1:0] tx_seq = '0;

  // Mirror of the receiver state, starting from its reset values.
  logic [slr_pkg::SEQ_W-1:0] last_seq   = '0;
  bit                        fresh_link = 1'b1;
  bit                        link_live  = 1'b0;
  bit                        hold_used [HOLD_SLOTS] = '{default: 1'b0};
  logic [slr_pkg::SEQ_W-1:0] hold_seq  [HOLD_SLOTS];
  logic [slr_pkg::TAG_W-1:0] hold_tag  [HOLD_SLOTS];
  int unsigned               idle_count = 0;
  int unsigned               ka_count   = 0;
  bit                        ka_sent    = 1'b0;

  // Mirror of the registers.
  logic [slr_pkg::TIMER_W-1:0]  lim_timeout   = slr_pkg::TIMEOUT_RST;
  logic [slr_pkg::TIMER_W-1:0]  lim_ka_first  = slr_pkg::KA_FIRST_RST;
  logic [slr_pkg::TIMER_W-1:0]  lim_ka_period = slr_pkg::KA_PERIOD_RST;
  logic [slr_pkg::GAPCFG_W-1:0] lim_max_gap   = slr_pkg::MAX_GAP_RST;
  logic [slr_pkg::SEQ_W-1:0]    lim_stale_gap = slr_pkg::STALE_GAP_RST;

  // Records one action of the word being forecast.
  function automatic void note(slr_pkg::act_t a, logic [slr_pkg::SEQ_W-1:0] s,
                               logic [slr_pkg::TAG_W-1:0] t);
    report_t r;
    if (word_actions.size() >= MAX_ACTIONS) return;
    r.act  = a;
    r.seq  = s;
    r.tag  = t;
    r.last = 1'b0;
    word_actions.push_back(r);
  endfunction

  function automatic int held_slot(logic [slr_pkg::SEQ_W-1:0] s);
    for (int i = 0; i < HOLD_SLOTS; i++)
      if (hold_used[i] && hold_seq[i] == s) return i;
    return -1;
  endfunction

  // Link reset: drops the connection, forgets the order and the held frames.
  function automatic void drop_link();
    if (link_live) begin
      link_live = 1'b0;
      note(slr_pkg::ACT_DISCONNECTED, '0, '0);
    end
    last_seq   = '0;
    fresh_link = 1'b1;
    foreach (hold_used[i]) hold_used[i] = 1'b0;
    note(slr_pkg::ACT_LINK_RESET, '0, '0);
  endfunction

  // Orders a valid data frame by its gap to the last delivered sequence.
  function automatic void take_data(logic [slr_pkg::SEQ_W-1:0] s,
                                    logic [slr_pkg::TAG_W-1:0] t);
    logic [slr_pkg::SEQ_W-1:0] gap;
    logic [slr_pkg::SEQ_W-1:0] ceiling;
    logic [slr_pkg::SEQ_W-1:0] want;
    int                        span;
    int                        h;
    bit                        stored;
    if (fresh_link) begin
      last_seq   = s - slr_pkg::SEQ_W'(1);
      fresh_link = 1'b0;
    end
    gap     = s - last_seq;
    ceiling = (int'(lim_max_gap) > int'(slr_pkg::GAP_CEILING)) ?
              slr_pkg::SEQ_W'(slr_pkg::GAP_CEILING) : slr_pkg::SEQ_W'(lim_max_gap);
    if (gap == slr_pkg::SEQ_W'(1)) begin
      last_seq = s;
      note(slr_pkg::ACT_PUBLISH, s, t);
      for (int k = 0; k < int'(slr_pkg::DRAIN_LIMIT) && k < HOLD_SLOTS; k++) begin
        h = held_slot(last_seq + slr_pkg::SEQ_W'(1));
        if (h < 0) break;
        last_seq     = hold_seq[h];
        hold_used[h] = 1'b0;
        note(slr_pkg::ACT_PUBLISH, hold_seq[h], hold_tag[h]);
      end
    end else if (gap == '0 || gap > lim_stale_gap) begin
      note(slr_pkg::ACT_DISCARD, '0, t);
    end else if (gap > ceiling) begin
      drop_link();
      note(slr_pkg::ACT_DISCARD, '0, t);
    end else begin
      // Ask for every missing number that is not already held.
      span = int'(gap);
      for (int i = 1; i < span; i++) begin
        want = last_seq + slr_pkg::SEQ_W'(i);
        if (held_slot(want) < 0) note(slr_pkg::ACT_RETRY, want, '0);
      end
      if (held_slot(s) >= 0) begin
        note(slr_pkg::ACT_DISCARD, '0, t);
      end else begin
        stored = 1'b0;
        for (int i = 0; i < HOLD_SLOTS && !stored; i++) begin
          if (!hold_used[i]) begin
            hold_used[i] = 1'b1;
            hold_seq[i]  = s;
            hold_tag[i]  = t;
            stored       = 1'b1;
          end
        end
        if (!stored) note(slr_pkg::ACT_DISCARD, '0, t);
      end
    end
  endfunction

  // One timer tick: idle timeout first, then the keepalive timer.
  function automatic void take_tick();
    int unsigned lim;
    int unsigned klim;
    lim = (lim_timeout == '0) ? 1 : int'(lim_timeout);
    if (idle_count < 'hFFFF) idle_count++;
    if (idle_count >= lim) begin
      idle_count = 0;
      drop_link();
    end
    klim = ka_sent ? int'(lim_ka_period) : int'(lim_ka_first);
    if (klim == 0) klim = 1;
    if (ka_count < 'hFFFF) ka_count++;
    if (ka_count >= klim) begin
      ka_count = 0;
      ka_sent  = 1'b1;
      note(slr_pkg::ACT_KEEPALIVE, '0, '0);
    end
  endfunction

  // Works out the result words an accepted input word causes and files them.
  function automatic void forecast_actions(word_t w);
    report_t r;
    word_actions.delete();
    if (w.command == slr_pkg::CMD_TICK) begin
      take_tick();
    end else if (w.len < slr_pkg::LEN_W'(slr_pkg::MIN_FRAME_LEN) || w.xsum != '0 ||
                 int'(w.tag) >= int'(slr_pkg::TAG_COUNT)) begin
      note(slr_pkg::ACT_DISCARD, '0, w.tag);
    end else begin
      case (w.ftype)
        slr_pkg::FT_DATA: begin
          take_data(w.seq, w.tag);
          idle_count = 0;
        end
        slr_pkg::FT_KEEPALIVE: begin
          if (!link_live) begin
            link_live = 1'b1;
            note(slr_pkg::ACT_CONNECTED, '0, '0);
          end
          idle_count = 0;
          note(slr_pkg::ACT_DISCARD, '0, w.tag);
        end
        slr_pkg::FT_RETRY: begin
          note(slr_pkg::ACT_RETRANSMIT, w.rseq, '0);
          note(slr_pkg::ACT_DISCARD, '0, w.tag);
        end
        slr_pkg::FT_RESET: begin
          drop_link();
          note(slr_pkg::ACT_DISCARD, '0, w.tag);
        end
        default: note(slr_pkg::ACT_DISCARD, '0, w.tag);
      endcase
    end
    if (word_actions.size() > 0) begin
      r      = word_actions.pop_back();
      r.last = 1'b1;
      word_actions.push_back(r);
    end
    foreach (word_actions[i]) due_actions.push_back(word_actions[i]);
  endfunction

  function automatic void log_fault(string why, report_t want, report_t got);
    fault_count++;
    if (fault_count <= FAULT_SHOWN)
      $display("mismatch (%s): expected act %0d seq %0d tag %0d last %0b, %s",
               why, want.act, want.seq, want.tag, want.last,
               $sformatf("got act %0d seq %0d tag %0d last %0b",
                         got.act, got.seq, got.tag, got.last));
  endfunction

  // Word builders.
  function automatic word_t any_word();
    word_t w;
    w.command = 1'($urandom);
    w.ftype   = slr_pkg::FTYPE_W'($urandom);
    w.seq     = slr_pkg::SEQ_W'($urandom);
    w.rseq    = slr_pkg::SEQ_W'($urandom);
    w.len     = slr_pkg::LEN_W'($urandom);
    w.xsum    = slr_pkg::XOR_W'($urandom);
    w.tag     = slr_pkg::TAG_W'($urandom);
    return w;
  endfunction

  function automatic word_t tick_word();
    word_t w;
    w         = any_word();
    w.command = slr_pkg::CMD_TICK;
    return w;
  endfunction

  // A well-formed frame with random length, tag and retry byte.
  function automatic word_t frame_word(logic [slr_pkg::FTYPE_W-1:0] ft,
                                       logic [slr_pkg::SEQ_W-1:0] s);
    word_t w;
    w         = any_word();
    w.command = slr_pkg::CMD_FRAME;
    w.ftype   = ft;
    w.seq     = s;
    w.xsum    = '0;
    case ($urandom_range(0, 9))
      0:       w.len = slr_pkg::LEN_W'(slr_pkg::MIN_FRAME_LEN);
      1:       w.len = '1;
      default: w.len = slr_pkg::LEN_W'($urandom_range(slr_pkg::MIN_FRAME_LEN,
                                                      (1 << slr_pkg::LEN_W) - 1));
    endcase
    return w;
  endfunction

  function automatic void queue_word(word_t w);
    outgoing_words.push_back(w);
    words_queued++;
  endfunction

  // Random phase: mostly in-order or lightly shuffled data runs, plus ticks,
  // control frames, stale and far-off numbers and broken frames.
  function automatic void fill_phase(int n);
    int                        made;
    int                        pick;
    int                        k;
    int                        j;
    logic [slr_pkg::SEQ_W-1:0] order [5];
    logic [slr_pkg::SEQ_W-1:0] swap;
    word_t                     w;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 42) begin
        k = $urandom_range(1, 5);
        for (int i = 0; i < k; i++) order[i] = tx_seq + slr_pkg::SEQ_W'(i);
        for (int i = k - 1; i > 0; i--) begin
          j        = $urandom_range(0, i);
          swap     = order[i];
          order[i] = order[j];
          order[j] = swap;
        end
        for (int i = 0; i < k; i++) queue_word(frame_word(slr_pkg::FT_DATA, order[i]));
        tx_seq = tx_seq + slr_pkg::SEQ_W'(k);
        made   = made + k;
      end else begin
        if (pick < 48) begin
          w = frame_word(slr_pkg::FT_DATA, tx_seq - slr_pkg::SEQ_W'($urandom_range(1, 20)));
        end else if (pick < 51) begin
          tx_seq = tx_seq + slr_pkg::SEQ_W'($urandom_range(6, 250));
          w      = frame_word(slr_pkg::FT_DATA, tx_seq);
          tx_seq = tx_seq + slr_pkg::SEQ_W'(1);
        end else if (pick < 78) begin
          w = tick_word();
        end else if (pick < 85) begin
          w = frame_word(slr_pkg::FT_KEEPALIVE, slr_pkg::SEQ_W'($urandom));
        end else if (pick < 89) begin
          w = frame_word(slr_pkg::FT_RETRY, slr_pkg::SEQ_W'($urandom));
        end else if (pick < 91) begin
          w = frame_word(slr_pkg::FT_RESET, slr_pkg::SEQ_W'($urandom));
        end else if (pick < 94) begin
          w = frame_word(slr_pkg::FTYPE_W'($urandom_range(FT_OTHER_FIRST, FT_OTHER_LAST)),
                         slr_pkg::SEQ_W'($urandom));
        end else begin
          w = frame_word(slr_pkg::FTYPE_W'($urandom), tx_seq);
          if ($urandom_range(0, 1) == 0)
            w.len = slr_pkg::LEN_W'($urandom_range(0, slr_pkg::MIN_FRAME_LEN - 1));
          else
            w.xsum = slr_pkg::XOR_W'($urandom_range(1, (1 << slr_pkg::XOR_W) - 1));
        end
        queue_word(w);
        made++;
      end
    end
  endfunction

  // Register write; the predictor's copy is updated as the write is driven.
  task automatic write_reg(logic [slr_pkg::CFG_ADDR_W-1:0] idx,
                           logic [slr_pkg::CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      slr_pkg::CFG_TIMEOUT:   lim_timeout   = val;
      slr_pkg::CFG_KA_FIRST:  lim_ka_first  = val;
      slr_pkg::CFG_KA_PERIOD: lim_ka_period = val;
      slr_pkg::CFG_MAX_GAP:   lim_max_gap   = val[slr_pkg::GAPCFG_W-1:0];
      slr_pkg::CFG_STALE_GAP: lim_stale_gap = val[slr_pkg::SEQ_W-1:0];
      default: ;
    endcase
  endtask

  // Writes every register; unused upper bits of the narrow ones are random.
  task automatic set_link(logic [slr_pkg::TIMER_W-1:0] tmo,
                          logic [slr_pkg::TIMER_W-1:0] ka_first,
                          logic [slr_pkg::TIMER_W-1:0] ka_period,
                          logic [slr_pkg::GAPCFG_W-1:0] gap_max,
                          logic [slr_pkg::SEQ_W-1:0] gap_stale);
    logic [slr_pkg::CFG_W-1:0] val;
    write_reg(slr_pkg::CFG_TIMEOUT, tmo);
    write_reg(slr_pkg::CFG_KA_FIRST, ka_first);
    write_reg(slr_pkg::CFG_KA_PERIOD, ka_period);
    val = slr_pkg::CFG_W'($urandom);
    val[slr_pkg::GAPCFG_W-1:0] = gap_max;
    write_reg(slr_pkg::CFG_MAX_GAP, val);
    val = slr_pkg::CFG_W'($urandom);
    val[slr_pkg::SEQ_W-1:0] = gap_stale;
    write_reg(slr_pkg::CFG_STALE_GAP, val);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Holds the sender back until every word is taken and every result seen,
  // then lets a word that yields nothing finish inside the block.
  task automatic settle();
    while (words_taken != words_queued || due_actions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Input driver: presents queued words, holds them while stalled and
  // inserts idle bursts after some of them.
  word_t cur_word;
  int    in_gap = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid      <= 1'b0;
      in_command    <= 1'b0;
      in_frame_type <= '0;
      in_seq        <= '0;
      in_retry_seq  <= '0;
      in_frame_len  <= '0;
      in_xor_sum    <= '0;
      in_tag        <= '0;
      in_gap         = 0;
    end else begin
      if (in_valid && !in_stall) begin
        forecast_actions(cur_word);
        words_taken++;
      end
      if (in_valid && in_stall) begin
        // The word stays put until the block takes it.
      end else if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (outgoing_words.size() > 0) begin
        cur_word       = outgoing_words.pop_front();
        in_command    <= cur_word.command;
        in_frame_type <= cur_word.ftype;
        in_seq        <= cur_word.seq;
        in_retry_seq  <= cur_word.rseq;
        in_frame_len  <= cur_word.len;
        in_xor_sum    <= cur_word.xsum;
        in_tag        <= cur_word.tag;
        in_valid      <= 1'b1;
        if (!calm && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 4);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result monitor: checks each accepted word and stalls in random bursts.
  int out_hold = 0;

  always @(posedge clk) begin
    report_t got;
    report_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_hold   = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got.act  = slr_pkg::act_t'(out_action);
        got.seq  = out_seq;
        got.tag  = out_tag;
        got.last = out_last;
        if (due_actions.size() == 0) begin
          want = '0;
          log_fault("unexpected word", want, got);
        end else begin
          want = due_actions.pop_front();
          if (got !== want) log_fault("wrong field", want, got);
        end
      end
      if (out_hold > 0) begin
        out_hold--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_hold   = $urandom_range(1, 4) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Run sequence: directed words at the reset settings, then random phases
  // across several register settings, the last one without idling.
  initial begin
    word_t w;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // First frame, duplicate, holds with retries, held duplicate, full drain.
    queue_word(frame_word(slr_pkg::FT_DATA, 8'd10));
    queue_word(frame_word(slr_pkg::FT_DATA, 8'd10));
    queue_word(frame_word(slr_pkg::FT_DATA, 8'd15));
    queue_word(frame_word(slr_pkg::FT_DATA, 8'd13));
    queue_word(frame_word(slr_pkg::FT_DATA, 8'd13));
    queue_word(frame_word(slr_pkg::FT_DATA, 8'd14));
    queue_word(frame_word(slr_pkg::FT_DATA, 8'd12));
    queue_word(frame_word(slr_pkg::FT_DATA, 8'd11));
    queue_word(frame_word(slr_pkg::FT_DATA, 8'd17));
    queue_word(frame_word(slr_pkg::FT_DATA, 8'd16));
    // Large gap with the link down, connect, large gap with the link up.
    queue_word(frame_word(slr_pkg::FT_DATA, 8'd200));
    queue_word(frame_word(slr_pkg::FT_KEEPALIVE, 8'd0));
    queue_word(frame_word(slr_pkg::FT_KEEPALIVE, 8'd255));
    queue_word(frame_word(slr_pkg::FT_DATA, 8'd0));
    queue_word(frame_word(slr_pkg::FT_DATA, 8'd20));
    // Stale frame, retry frame, reset frame with the link up.
    queue_word(frame_word(slr_pkg::FT_DATA, 8'd50));
    queue_word(frame_word(slr_pkg::FT_DATA, 8'd45));
    w      = frame_word(slr_pkg::FT_RETRY, 8'd3);
    w.rseq = 8'hAA;
    queue_word(w);
    queue_word(frame_word(slr_pkg::FT_KEEPALIVE, 8'd1));
    queue_word(frame_word(slr_pkg::FT_RESET, 8'd2));
    // Sequence wrap, unknown types, short and corrupted frames.
    queue_word(frame_word(slr_pkg::FT_DATA, 8'd255));
    queue_word(frame_word(slr_pkg::FT_DATA, 8'd0));
    queue_word(frame_word(FT_OTHER_FIRST, 8'd1));
    queue_word(frame_word(FT_OTHER_LAST, 8'd1));
    w     = frame_word(slr_pkg::FT_DATA, 8'd1);
    w.len = '0;
    queue_word(w);
    w     = frame_word(slr_pkg::FT_DATA, 8'd1);
    w.len = slr_pkg::LEN_W'(slr_pkg::MIN_FRAME_LEN - 1);
    queue_word(w);
    w      = frame_word(slr_pkg::FT_DATA, 8'd1);
    w.xsum = '1;
    queue_word(w);
    tx_seq = 8'd1;
    settle();

    // Lowest settings: every tick times out, keepalive on every tick.
    set_link(16'd0, 16'd1, 16'd1, 3'd2, 8'd6);
    fill_phase(PHASE_WORDS);
    settle();

    // Highest settings, with a gap limit above the ceiling.
    set_link('1, '1, '1, 3'd7, 8'd255);
    fill_phase(PHASE_WORDS);
    settle();

    set_link(16'd12, 16'd3, 16'd9, 3'd5, slr_pkg::SEQ_W'($urandom_range(6, 255)));
    fill_phase(PHASE_WORDS);
    settle();

    set_link(slr_pkg::TIMER_W'($urandom_range(2, 30)),
             slr_pkg::TIMER_W'($urandom_range(1, 15)),
             slr_pkg::TIMER_W'($urandom_range(2, 25)),
             slr_pkg::GAPCFG_W'($urandom_range(2, 6)),
             slr_pkg::SEQ_W'($urandom_range(6, 255)));
    fill_phase(PHASE_WORDS);
    settle();

    calm = 1'b1;
    set_link(16'd40, 16'd20, 16'd15, 3'd4, 8'd240);
    fill_phase(PHASE_WORDS);
    settle();

    if (fault_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

[filelist.f]
sv/slr_pkg.sv
sv/slr_seq.sv
sv/slr_datapath.sv
sv/slr_result.sv
sv/sequenced_link_receiver_unit.sv
tb/sequenced_link_receiver_unit_tb.sv
